@@ rtl/core/sgn_pkg.sv @@
`timescale 1ns / 1ps

package sgn_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;
  localparam int unsigned MinSize   = 5;
  localparam int unsigned AddrW     = 10;
  localparam int unsigned SizeW     = 11;
  localparam int unsigned PixW      = 8;
  localparam int unsigned GradW     = 11;
  localparam int unsigned MagW      = 15;
  localparam int unsigned SumW      = 21;
  localparam int unsigned RadW      = 30;
  localparam int unsigned OpaW      = 16;
  localparam int unsigned OpbW      = 12;
  localparam int unsigned ProdW     = OpaW + OpbW;
  localparam int unsigned OutDataW  = 64;
  localparam int unsigned OutUserW  = 3;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_LOW    = 2'd2,
    CFG_HIGH   = 2'd3
  } cfg_idx_e;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v,
                                                  input logic [SizeW-1:0] maxv);
    logic [SizeW-1:0] r;
    begin
      r = v;
      if (v < SizeW'(MinSize)) r = SizeW'(MinSize);
      else if (v > maxv) r = maxv;
      return r;
    end
  endfunction

  function automatic logic signed [OpaW-1:0] mag_diff(input logic [MagW-1:0] x,
                                                      input logic [MagW-1:0] y);
    begin
      return $signed({1'b0, x}) - $signed({1'b0, y});
    end
  endfunction

endpackage

@@ rtl/core/sobel_gradient_nms_edge_classifier.sv @@
`timescale 1ns / 1ps
// Sobel gradient, fixed-point magnitude and non-maximum suppression edge stage.
// Input stream: one 8-bit grey pixel per transaction, raster order, frame size
// set by the width and height registers (clamped to 5..1024).
// Output stream: one transaction per interior pixel (two or more away from
// every frame edge): row, column, both gradients and magnitude in tdata,
// local-max, weak and strong flags in tuser, tlast on the frame's last one.
// Configuration: write enable, register index and data; write only when idle.
// A pixel with no gradient formed yet only updates the window and line stores;
// one with a gradient but no result also squares, takes the 15-step radix-4
// square root and stores the magnitude; an interior pixel adds the four products
// of the suppression test. The squares and products share one multiplier.
// s_axis_tready is high only while the sequencer waits for a pixel; a result
// sits in an output register, so the next pixel is taken while it waits.
// If the receiver stalls, the sequencer holds its finished result until the
// output register empties.
// Reset clears the counters, the sequencer and the output valid; line stores
// are not cleared and are filled by the first rows of each frame.
module sobel_gradient_nms_edge_classifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] pixel
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [9:0] out_row, [19:10] out_col, [30:20] grad_down, [41:31] grad_right,
  // [56:42] magnitude, [63:57] zero
  output logic [sgn_pkg::OutDataW-1:0]     m_axis_tdata,
  // [0] is_local_max, [1] weak_edge, [2] strong_edge
  output logic [sgn_pkg::OutUserW-1:0]     m_axis_tuser,
  output logic                             m_axis_tlast,  // last_of_frame
  input  logic                             cfg_we_i,
  input  logic [1:0]                       cfg_idx_i,
  input  logic [sgn_pkg::MagW-1:0]         cfg_data_i
);
  import sgn_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_WIN, ST_SQ1, ST_SQ2, ST_SQ3, ST_ROOT, ST_MAG, ST_NMS, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    OCT_A, OCT_B, OCT_C, OCT_D
  } oct_e;

  state_e state_q;

  logic [SizeW-1:0] width_q, height_q;
  logic [MagW-1:0]  low_q, high_q;
  logic [AddrW-1:0] row_q, col_q;
  logic [AddrW-1:0] r_q, c_q;
  logic [PixW-1:0]  pix_q;

  logic [PixW-1:0] gwin_q [3][3];
  logic [MagW-1:0] mwin_q [3][3];
  logic signed [GradW-1:0] gr_q, gc_q, held_d_q, held_r_q, cd_q, cr_q;
  logic [SumW-1:0] sq_acc_q;
  logic signed [ProdW-1:0] prod_q, pf_q;
  logic cmp1_q;
  logic [2:0] nms_k_q;

  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;
  logic              out_last_q;

  logic [SizeW-1:0] w, h;
  logic             accept;
  logic [SizeW-1:0] row_t, col_n, row_n;
  logic [AddrW-1:0] col_w, row_w;
  logic [AddrW-1:0] rd_c, wr_c;

  logic [PixW-1:0] g1_rd, g2_rd;
  logic [MagW-1:0] m1_rd, m2_rd;
  logic [GradW-1:0] dl_rd, rl_rd;
  logic [PixW-1:0] t0, t1, t2, m0, b0, b1, b2;
  logic signed [GradW:0] gr_n, gc_n;

  logic            sq_start, sq_done;
  logic [MagW-1:0] root;

  logic signed [OpbW-1:0] dr, dc;
  oct_e oct;
  logic signed [OpaW-1:0] mul_a;
  logic signed [OpbW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic grad_zero, out_free;
  logic [SizeW-1:0] orow, ocol;

  assign w = clamp_size(width_q, SizeW'(MaxWidth));
  assign h = clamp_size(height_q, SizeW'(MaxHeight));

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_w = col_q;
    row_t = {1'b0, row_q};
    if ({1'b0, col_q} >= w) begin
      col_w = '0;
      row_t = {1'b0, row_q} + SizeW'(1);
    end
    row_w = (row_t >= h) ? '0 : row_t[AddrW-1:0];
    col_n = {1'b0, col_w} + SizeW'(1);
    row_n = {1'b0, row_w} + SizeW'(1);
  end

  assign rd_c = col_w - AddrW'(1);
  assign wr_c = c_q - AddrW'(1);

  sgn_line_ram #(.Depth(MaxWidth), .Width(PixW)) u_grey_one (
    .clk_i, .we_i(state_q == ST_WIN), .waddr_i(c_q), .wdata_i(pix_q),
    .re_i(accept), .raddr_i(col_w), .rdata_o(g1_rd)
  );
  sgn_line_ram #(.Depth(MaxWidth), .Width(PixW)) u_grey_two (
    .clk_i, .we_i(state_q == ST_WIN), .waddr_i(c_q), .wdata_i(g1_rd),
    .re_i(accept), .raddr_i(col_w), .rdata_o(g2_rd)
  );
  sgn_line_ram #(.Depth(MaxWidth), .Width(MagW)) u_mag_one (
    .clk_i, .we_i(state_q == ST_MAG), .waddr_i(wr_c), .wdata_i(root),
    .re_i(accept), .raddr_i(rd_c), .rdata_o(m1_rd)
  );
  sgn_line_ram #(.Depth(MaxWidth), .Width(MagW)) u_mag_two (
    .clk_i, .we_i(state_q == ST_MAG), .waddr_i(wr_c), .wdata_i(m1_rd),
    .re_i(accept), .raddr_i(rd_c), .rdata_o(m2_rd)
  );
  sgn_line_ram #(.Depth(MaxWidth), .Width(GradW)) u_down_line (
    .clk_i, .we_i(state_q == ST_MAG), .waddr_i(wr_c), .wdata_i(gr_q),
    .re_i(accept), .raddr_i(rd_c), .rdata_o(dl_rd)
  );
  sgn_line_ram #(.Depth(MaxWidth), .Width(GradW)) u_right_line (
    .clk_i, .we_i(state_q == ST_MAG), .waddr_i(wr_c), .wdata_i(gc_q),
    .re_i(accept), .raddr_i(rd_c), .rdata_o(rl_rd)
  );

  // window after shift: left = old middle, middle = old right, right = new
  assign t0 = gwin_q[0][1];
  assign t1 = gwin_q[0][2];
  assign t2 = g2_rd;
  assign m0 = gwin_q[1][1];
  assign b0 = gwin_q[2][1];
  assign b1 = gwin_q[2][2];
  assign b2 = pix_q;

  always_comb begin
    gr_n = $signed({4'd0, b0}) + $signed({3'd0, b1, 1'b0}) + $signed({4'd0, b2})
         - $signed({4'd0, t0}) - $signed({3'd0, t1, 1'b0}) - $signed({4'd0, t2});
    gc_n = $signed({4'd0, t2}) + $signed({3'd0, g1_rd, 1'b0}) + $signed({4'd0, b2})
         - $signed({4'd0, t0}) - $signed({3'd0, m0, 1'b0}) - $signed({4'd0, b0});
  end

  assign sq_start = (state_q == ST_SQ3);

  sgn_isqrt u_isqrt (
    .clk_i, .rst_ni, .start_i(sq_start),
    .sum_i(sq_acc_q + prod_q[SumW-1:0]),
    .done_o(sq_done), .root_o(root)
  );

  assign grad_zero = (cd_q == '0) && (cr_q == '0);

  always_comb begin
    if (cr_q < 0) begin
      dc = -OpbW'(cr_q);
      dr = -OpbW'(cd_q);
    end else begin
      dc = OpbW'(cr_q);
      dr = OpbW'(cd_q);
    end
    if (dr >= 0) oct = (dr > dc) ? OCT_A : OCT_B;
    else         oct = (-dr < dc) ? OCT_C : OCT_D;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ1: begin
        mul_a = OpaW'(gr_q);
        mul_b = OpbW'(gr_q);
      end
      ST_SQ2: begin
        mul_a = OpaW'(gc_q);
        mul_b = OpbW'(gc_q);
      end
      ST_NMS: begin
        unique case (oct)
          OCT_A: begin
            case (nms_k_q[1:0])
              2'd0:    begin mul_a = mag_diff(mwin_q[2][2], mwin_q[2][1]); mul_b = dc; end
              2'd1:    begin mul_a = mag_diff(mwin_q[1][1], mwin_q[2][1]); mul_b = dr; end
              2'd2:    begin mul_a = mag_diff(mwin_q[0][0], mwin_q[0][1]); mul_b = dc; end
              default: begin mul_a = mag_diff(mwin_q[1][1], mwin_q[0][1]); mul_b = dr; end
            endcase
          end
          OCT_B: begin
            case (nms_k_q[1:0])
              2'd0:    begin mul_a = mag_diff(mwin_q[0][0], mwin_q[1][0]); mul_b = dr; end
              2'd1:    begin mul_a = mag_diff(mwin_q[1][1], mwin_q[1][0]); mul_b = dc; end
              2'd2:    begin mul_a = mag_diff(mwin_q[2][2], mwin_q[1][2]); mul_b = dr; end
              default: begin mul_a = mag_diff(mwin_q[1][1], mwin_q[1][2]); mul_b = dc; end
            endcase
          end
          OCT_C: begin
            case (nms_k_q[1:0])
              2'd0:    begin mul_a = mag_diff(mwin_q[1][0], mwin_q[2][0]); mul_b = dr; end
              2'd1:    begin mul_a = mag_diff(mwin_q[1][1], mwin_q[1][0]); mul_b = dc; end
              2'd2:    begin mul_a = mag_diff(mwin_q[1][2], mwin_q[0][2]); mul_b = dr; end
              default: begin mul_a = mag_diff(mwin_q[1][1], mwin_q[1][2]); mul_b = dc; end
            endcase
          end
          default: begin
            case (nms_k_q[1:0])
              2'd0:    begin mul_a = mag_diff(mwin_q[1][1], mwin_q[2][1]); mul_b = dr; end
              2'd1:    begin mul_a = mag_diff(mwin_q[2][1], mwin_q[2][0]); mul_b = dc; end
              2'd2:    begin mul_a = mag_diff(mwin_q[1][1], mwin_q[0][1]); mul_b = dr; end
              default: begin mul_a = mag_diff(mwin_q[0][1], mwin_q[0][2]); mul_b = dc; end
            endcase
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign out_free = !out_valid_q || m_axis_tready;
  assign orow = {1'b0, r_q} - SizeW'(2);
  assign ocol = {1'b0, c_q} - SizeW'(2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= SizeW'(640);
      height_q    <= SizeW'(480);
      low_q       <= MagW'(160);
      high_q      <= MagW'(320);
      row_q       <= '0;
      col_q       <= '0;
      nms_k_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_WIDTH:  width_q  <= cfg_data_i[SizeW-1:0];
          CFG_HEIGHT: height_q <= cfg_data_i[SizeW-1:0];
          CFG_LOW:    low_q    <= cfg_data_i;
          CFG_HIGH:   high_q   <= cfg_data_i;
          default:    ;
        endcase
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (col_n >= w) begin
              col_q <= '0;
              row_q <= (row_n >= h) ? '0 : row_n[AddrW-1:0];
            end else begin
              col_q <= col_n[AddrW-1:0];
              row_q <= row_w;
            end
            state_q <= ST_WIN;
          end
        end
        ST_WIN: begin
          state_q <= (r_q >= AddrW'(2) && c_q >= AddrW'(2)) ? ST_SQ1 : ST_IDLE;
        end
        ST_SQ1:  state_q <= ST_SQ2;
        ST_SQ2:  state_q <= ST_SQ3;
        ST_SQ3:  state_q <= ST_ROOT;
        ST_ROOT: begin
          if (sq_done) begin
            state_q <= ST_MAG;
          end
        end
        ST_MAG: begin
          nms_k_q <= '0;
          state_q <= (r_q >= AddrW'(4) && c_q >= AddrW'(4)) ? ST_NMS : ST_IDLE;
        end
        ST_NMS: begin
          nms_k_q <= nms_k_q + 3'd1;
          if (nms_k_q == 3'd4) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q   <= row_w;
      c_q   <= col_w;
      pix_q <= s_axis_tdata;
    end
    if (state_q == ST_WIN) begin
      for (int i = 0; i < 3; i++) begin
        gwin_q[i][0] <= gwin_q[i][1];
        gwin_q[i][1] <= gwin_q[i][2];
      end
      gwin_q[0][2] <= g2_rd;
      gwin_q[1][2] <= g1_rd;
      gwin_q[2][2] <= pix_q;
      gr_q <= gr_n[GradW-1:0];
      gc_q <= gc_n[GradW-1:0];
    end
    if (state_q == ST_SQ1 || state_q == ST_SQ2 || state_q == ST_NMS) begin
      prod_q <= mul_p;
    end
    if (state_q == ST_SQ2) begin
      sq_acc_q <= prod_q[SumW-1:0];
    end
    if (state_q == ST_MAG) begin
      cd_q     <= held_d_q;
      cr_q     <= held_r_q;
      held_d_q <= dl_rd;
      held_r_q <= rl_rd;
      for (int i = 0; i < 3; i++) begin
        mwin_q[i][0] <= mwin_q[i][1];
        mwin_q[i][1] <= mwin_q[i][2];
      end
      mwin_q[0][2] <= m2_rd;
      mwin_q[1][2] <= m1_rd;
      mwin_q[2][2] <= root;
    end
    if (state_q == ST_NMS) begin
      if (nms_k_q[0]) begin
        pf_q <= prod_q;
      end
      if (nms_k_q == 3'd2) begin
        cmp1_q <= (pf_q <= prod_q);
      end
      if (nms_k_q == 3'd4) begin
        cmp1_q <= cmp1_q && (pf_q < prod_q) && !grad_zero;
      end
    end
    if (state_q == ST_OUT && out_free) begin
      out_data_q <= {7'd0, mwin_q[1][1], cr_q, cd_q, ocol[AddrW-1:0], orow[AddrW-1:0]};
      out_user_q <= {cmp1_q && (mwin_q[1][1] > high_q),
                     cmp1_q && (mwin_q[1][1] > low_q),
                     cmp1_q};
      out_last_q <= (orow == h - SizeW'(3)) && (ocol == w - SizeW'(3));
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ rtl/core/sgn_line_ram.sv @@
`timescale 1ns / 1ps

module sgn_line_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/core/sgn_isqrt.sv @@
`timescale 1ns / 1ps

module sgn_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sgn_pkg::SumW-1:0]   sum_i,
  output logic                       done_o,
  output logic [sgn_pkg::MagW-1:0]   root_o
);
  import sgn_pkg::*;

  logic [RadW-1:0] rem_q, res_q, bit_q;
  logic            busy_q, done_q;
  logic [RadW-1:0] trial;

  assign trial  = res_q + bit_q;
  assign done_o = done_q;
  assign root_o = res_q[MagW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, sum_i, 8'd0};
      res_q <= '0;
      bit_q <= RadW'(1) << (RadW - 2);
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

endmodule
